FILE: rtl/core/skvt_pkg.sv
`default_nettype none

package skvt_pkg;

  localparam int unsigned CapacityDefault = 16;
  localparam int unsigned KeyW            = 32;
  localparam int unsigned ValW            = 32;
  localparam int unsigned CountOutW       = 5;
  localparam int unsigned InDataW         = 72;
  localparam int unsigned OutDataW        = 40;

  typedef enum logic [1:0] {
    CMD_SEARCH = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic                   valid;
    logic signed [KeyW-1:0] key;
    logic signed [ValW-1:0] value;
  } entry_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic                   cmp_en;
    logic                   ins_en;
    logic                   rem_en;
    logic signed [KeyW-1:0] key;
    logic signed [ValW-1:0] value;
  } ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/skvt_cell.sv
`default_nettype none

module skvt_cell
  import skvt_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  ctrl_t  ctrl_i,
  input  entry_t left_i,
  input  logic   left_lt_i,
  input  entry_t right_i,
  output entry_t entry_o,
  output logic   lt_o,
  output logic   eq_o
);

  logic                   valid_q, valid_d;
  logic signed [KeyW-1:0] key_q, key_d;
  logic signed [ValW-1:0] value_q, value_d;
  logic                   lt_q, lt_d;
  logic                   eq_q, eq_d;

  always_comb begin
    lt_d = lt_q;
    eq_d = eq_q;
    if (ctrl_i.cmp_en) begin
      lt_d = valid_q && (key_q < ctrl_i.key);
      eq_d = valid_q && (key_q == ctrl_i.key);
    end
  end

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    value_d = value_q;
    if (ctrl_i.ins_en && !lt_q) begin
      valid_d = valid_q | left_i.valid;
      if (left_lt_i) begin
        key_d   = ctrl_i.key;
        value_d = ctrl_i.value;
      end else begin
        key_d   = left_i.key;
        value_d = left_i.value;
      end
    end else if (ctrl_i.rem_en && !lt_q) begin
      valid_d = right_i.valid;
      key_d   = right_i.key;
      value_d = right_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      lt_q    <= 1'b0;
      eq_q    <= 1'b0;
    end else begin
      valid_q <= valid_d;
      lt_q    <= lt_d;
      eq_q    <= eq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  assign entry_o = '{valid: valid_q, key: key_q, value: value_q};
  assign lt_o    = lt_q;
  assign eq_o    = eq_q;

endmodule

`default_nettype wire

FILE: rtl/core/skvt_chain.sv
`default_nettype none

module skvt_chain
  import skvt_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ctrl_t                  ctrl_i,
  output logic                   hit_o,
  output logic                   full_o,
  output logic signed [ValW-1:0] found_o
);

  entry_t entry_w [CAPACITY];
  logic   lt_w    [CAPACITY];
  logic   eq_w    [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_w;
    entry_t right_w;
    logic   left_lt_w;

    if (i == 0) begin : g_first
      // virtual entry in front of the table: always below the key
      assign left_w    = '{valid: 1'b1, key: '0, value: '0};
      assign left_lt_w = 1'b1;
    end else begin : g_inner
      assign left_w    = entry_w[i-1];
      assign left_lt_w = lt_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '{valid: 1'b0, key: '0, value: '0};
    end else begin : g_body
      assign right_w = entry_w[i+1];
    end

    skvt_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl_i),
      .left_i    (left_w),
      .left_lt_i (left_lt_w),
      .right_i   (right_w),
      .entry_o   (entry_w[i]),
      .lt_o      (lt_w[i]),
      .eq_o      (eq_w[i])
    );
  end

  always_comb begin
    hit_o   = 1'b0;
    found_o = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_o   = hit_o | eq_w[i];
      found_o = found_o | (eq_w[i] ? entry_w[i].value : '0);
    end
  end

  assign full_o = entry_w[CAPACITY-1].valid;

endmodule

`default_nettype wire

FILE: rtl/core/sorted_key_value_table_unit.sv
// Sorted key/value table of CAPACITY entries kept as a row of cells in
// ascending signed key order. A request is taken on the s_axis side, every
// cell compares its key with the request key in the next cycle and
// registers the outcome, and then, once the output register can take the
// result, all cells shift together for an insert or remove while the result
// is loaded into the m_axis output register. One request is worked on at a
// time: the input is ready again only after the result has been loaded, and
// no new request is taken before that. A finished result may wait in the
// output register while the next request is already being compared. Keys
// and values need no clearing after reset.
`default_nettype none

module sorted_key_value_table_unit
  import skvt_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // command [1:0], key [33:2], value [65:34], zero [71:66]
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // status [1:0], found_value [33:2], entry_count [38:34], zero [39]
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_EXEC = 3'b100
  } state_e;

  state_e state_q, state_d;

  cmd_e                   cmd_q, cmd_d;
  logic signed [KeyW-1:0] key_q, key_d;
  logic signed [ValW-1:0] value_q, value_d;
  logic [CntW-1:0]        cnt_q, cnt_d;

  logic                   out_valid_q, out_valid_d;
  status_e                status_q, status_d;
  logic signed [ValW-1:0] found_q, found_d;
  logic [CountOutW-1:0]   count_out_q, count_out_d;

  ctrl_t                  ctrl;
  logic                   hit;
  logic                   full;
  logic signed [ValW-1:0] found_w;
  logic                   in_xfer;
  logic                   fire;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign fire            = (state_q == S_EXEC) && (!out_valid_q || m_axis_tready_i);

  skvt_chain #(
    .CAPACITY (CAPACITY)
  ) u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .hit_o   (hit),
    .full_o  (full),
    .found_o (found_w)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_xfer) state_d = S_CMP;
      S_CMP:  state_d = S_EXEC;
      S_EXEC: if (fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_d   = cmd_q;
    key_d   = key_q;
    value_d = value_q;
    if (in_xfer) begin
      cmd_d   = cmd_e'(s_axis_tdata_i[1:0]);
      key_d   = s_axis_tdata_i[33:2];
      value_d = s_axis_tdata_i[65:34];
    end
  end

  always_comb begin
    ctrl        = '{cmp_en: 1'b0, ins_en: 1'b0, rem_en: 1'b0, key: key_q, value: value_q};
    ctrl.cmp_en = (state_q == S_CMP);
    cnt_d       = cnt_q;
    status_d    = status_q;
    found_d     = found_q;
    count_out_d = count_out_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    if (fire) begin
      out_valid_d = 1'b1;
      found_d     = '0;
      unique case (cmd_q)
        CMD_INSERT: begin
          if (hit) begin
            status_d = ST_MISS;
          end else if (full) begin
            status_d = ST_FULL;
          end else begin
            status_d    = ST_OK;
            ctrl.ins_en = 1'b1;
            cnt_d       = cnt_q + CntW'(1);
          end
        end
        CMD_REMOVE: begin
          if (hit) begin
            status_d    = ST_OK;
            found_d     = found_w;
            ctrl.rem_en = 1'b1;
            cnt_d       = cnt_q - CntW'(1);
          end else begin
            status_d = ST_MISS;
          end
        end
        default: begin
          // search, unused code too
          status_d = hit ? ST_OK : ST_MISS;
          found_d  = hit ? found_w : '0;
        end
      endcase
      count_out_d = CountOutW'(cnt_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    key_q       <= key_d;
    value_q     <= value_d;
    status_q    <= status_d;
    found_q     <= found_d;
    count_out_q <= count_out_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, count_out_q, found_q, status_q};

endmodule

`default_nettype wire

FILE: rtl/core/skvt_checker.sv
`default_nettype none

module skvt_checker
  import skvt_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDefault
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid_i,
  input logic                s_axis_tready_o,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o
);

  logic [1:0]           status;
  logic [ValW-1:0]      found;
  logic [CountOutW-1:0] count;

  assign status = m_axis_tdata_o[1:0];
  assign found  = m_axis_tdata_o[33:2];
  assign count  = m_axis_tdata_o[38:34];

  // result held until its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result dropped or changed while stalled");

  // one request in flight: no new request right after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request taken while another is in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && status != ST_OK |-> found == '0)
    else $error("nonzero value on a failed request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && status == ST_FULL |-> count == CountOutW'(CAPACITY))
    else $error("full status with table not full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (status == ST_OK || status == ST_MISS || status == ST_FULL))
    else $error("unknown status code");

endmodule

bind sorted_key_value_table_unit skvt_checker #(
  .CAPACITY (CAPACITY)
) u_skvt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire

FILE: tb/sv/tb_sorted_key_value_table_unit.sv
`default_nettype none

module tb_sorted_key_value_table_unit;
  import skvt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = CapacityDefault;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic signed [KeyW-1:0] KeyMin = 32'sh8000_0000;
  localparam logic signed [KeyW-1:0] KeyMax = 32'sh7fff_ffff;
  localparam int unsigned PoolSize = 24;
  localparam int unsigned MaxReports = 10;

  typedef struct {
    logic [1:0]             status;
    logic signed [ValW-1:0] found;
    logic [CountOutW-1:0]   count;
  } table_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                req_valid = 1'b0;
  logic                req_ready;
  logic [InDataW-1:0]  req_data = '0;
  logic                rsp_valid;
  logic                rsp_ready = 1'b0;
  logic [OutDataW-1:0] rsp_data;

  // mirror of the table contents, kept in ascending key order
  logic signed [KeyW-1:0] mirror_key [Depth];
  logic signed [ValW-1:0] mirror_val [Depth];
  int                     mirror_count = 0;

  table_result_t          expected_results [$];
  logic signed [KeyW-1:0] key_pool [PoolSize];

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int mismatch_count = 0;

  sorted_key_value_table_unit #(
    .CAPACITY(Depth)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(req_valid),
    .s_axis_tready_o(req_ready),
    .s_axis_tdata_i (req_data),
    .m_axis_tvalid_o(rsp_valid),
    .m_axis_tready_i(rsp_ready),
    .m_axis_tdata_o (rsp_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // receiver side: random stalls plus an optional long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  function automatic table_result_t apply_request(logic [1:0] cmd,
                                                  logic signed [KeyW-1:0] key,
                                                  logic signed [ValW-1:0] val);
    table_result_t r;
    int pos;
    int i;
    bit hit;
    pos = 0;
    while (pos < mirror_count && mirror_key[pos] < key) pos++;
    hit = (pos < mirror_count) && (mirror_key[pos] == key);
    r.status = ST_MISS;
    r.found = '0;
    if (cmd == CMD_INSERT) begin
      if (hit) begin
        r.status = ST_MISS;
      end else if (mirror_count >= Depth) begin
        r.status = ST_FULL;
      end else begin
        for (i = mirror_count; i > pos; i--) begin
          mirror_key[i] = mirror_key[i-1];
          mirror_val[i] = mirror_val[i-1];
        end
        mirror_key[pos] = key;
        mirror_val[pos] = val;
        mirror_count++;
        r.status = ST_OK;
      end
    end else if (cmd == CMD_REMOVE) begin
      if (hit) begin
        r.found = mirror_val[pos];
        for (i = pos; i + 1 < mirror_count; i++) begin
          mirror_key[i] = mirror_key[i+1];
          mirror_val[i] = mirror_val[i+1];
        end
        mirror_count--;
        r.status = ST_OK;
      end
    end else if (hit) begin
      // search, and the unused command code behaves the same way
      r.found = mirror_val[pos];
      r.status = ST_OK;
    end
    r.count = CountOutW'(mirror_count);
    return r;
  endfunction

  always @(posedge clk) begin
    table_result_t want;
    table_result_t got;
    if (rst_n && rsp_valid && rsp_ready) begin
      got.status = rsp_data[1:0];
      got.found  = rsp_data[33:2];
      got.count  = rsp_data[38:34];
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports)
          $display("unexpected result transfer: status %0d value %0d count %0d",
                   got.status, got.found, got.count);
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status || got.found !== want.found ||
            got.count !== want.count) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports)
            $display("result mismatch: status %0d/%0d value %0d/%0d count %0d/%0d",
                     want.status, got.status, want.found, got.found,
                     want.count, got.count);
        end
      end
    end
  end

  task automatic send_request(logic [1:0] cmd, logic signed [KeyW-1:0] key,
                              logic signed [ValW-1:0] val);
    while ($urandom_range(99) < sender_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= {6'b0, val, key, cmd};
    do @(posedge clk); while (!req_ready);
    expected_results.push_back(apply_request(cmd, key, val));
  endtask

  task automatic test_empty_table();
    send_request(CMD_SEARCH, 32'sd0, 32'sd5);
    send_request(CMD_REMOVE, KeyMin, 32'sd0);
    send_request(CMD_UNUSED, -32'sd1, 32'sd0);
  endtask

  task automatic test_extreme_keys();
    send_request(CMD_INSERT, KeyMin, KeyMax);
    send_request(CMD_INSERT, KeyMax, KeyMin);
    send_request(CMD_INSERT, 32'sd0, -32'sd1);
    send_request(CMD_INSERT, -32'sd1, 32'sd0);
    send_request(CMD_INSERT, KeyMin, 32'sd77);
    send_request(CMD_SEARCH, KeyMax, 32'sd0);
    send_request(CMD_UNUSED, KeyMin, 32'sd0);
    send_request(CMD_REMOVE, 32'sd0, 32'sd0);
    send_request(CMD_REMOVE, 32'sd0, 32'sd0);
  endtask

  task automatic test_fill_to_full();
    int k;
    for (k = 1; k <= 13; k++)
      send_request(CMD_INSERT, k * 32'sd1000003 - 32'sd7, $urandom);
    send_request(CMD_INSERT, 32'sd12345, 32'sd1);
    // a duplicate is reported as such even with the table full
    send_request(CMD_INSERT, KeyMax, 32'sd2);
    send_request(CMD_REMOVE, KeyMax, 32'sd0);
  endtask

  function automatic logic signed [KeyW-1:0] pick_key();
    int roll;
    roll = $urandom_range(99);
    if (roll < 85) return key_pool[$urandom_range(PoolSize - 1)];
    if (roll < 95) return key_pool[$urandom_range(PoolSize - 1)] + ($urandom_range(1) ? 1 : -1);
    return $urandom;
  endfunction

  function automatic logic [1:0] pick_command(bit growing);
    int roll;
    roll = $urandom_range(99);
    if (roll < 5) return CMD_UNUSED;
    if (roll < 25) return CMD_SEARCH;
    if (roll < (growing ? 85 : 40)) return CMD_INSERT;
    return CMD_REMOVE;
  endfunction

  task automatic test_random_mix(int count, int idle_pct, int stall_pct);
    int n;
    int p;
    bit growing;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    key_pool[0] = KeyMin;
    key_pool[1] = KeyMax;
    key_pool[2] = 32'sd0;
    key_pool[3] = -32'sd1;
    for (p = 4; p < PoolSize; p++) key_pool[p] = $urandom;
    growing = 1'b1;
    for (n = 0; n < count; n++) begin
      // swing between filling and draining so both full and empty are reached
      if (n % 50 == 0) growing = (mirror_count < Depth / 2) ? 1'b1 : $urandom_range(1);
      send_request(pick_command(growing), pick_key(), $urandom);
    end
  endtask

  task automatic test_output_backpressure();
    int n;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_request = 200;
    for (n = 0; n < 40; n++)
      send_request(pick_command(n < 30), pick_key(), $urandom);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    receiver_stall_pct = 0;
    test_empty_table();
    test_extreme_keys();
    test_fill_to_full();
    test_random_mix(440, 0, 0);
    test_random_mix(440, 77, 0);
    test_output_backpressure();
    test_random_mix(440, 0, 77);
    test_random_mix(440, 17, 17);
    req_valid <= 1'b0;
    receiver_stall_pct = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/core/skvt_pkg.sv
rtl/core/skvt_cell.sv
rtl/core/skvt_chain.sv
rtl/core/sorted_key_value_table_unit.sv
rtl/core/skvt_checker.sv
tb/sv/tb_sorted_key_value_table_unit.sv
